### sv/blca_pkg.sv
package blca_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int LIFT_LEVELS = 10;
    localparam int NODE_W      = $clog2(MAX_NODES + 1);
    localparam int IDX_W       = $clog2(MAX_NODES);
    localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int ANC_AW      = LVL_W + IDX_W;
    localparam int ANC_DEPTH   = LIFT_LEVELS * (2 ** IDX_W);
    localparam int DW          = NODE_W + 1;

    // action codes
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P1_RD,
        ST_P1_WR,
        ST_D_RD,
        ST_D_CHK,
        ST_L_RD,
        ST_L_RD2,
        ST_L_WR,
        ST_Q_RDU,
        ST_Q_RDV,
        ST_Q_TOP,
        ST_LIFT_CHK,
        ST_LIFT_A,
        ST_LIFT_D,
        ST_AFTER,
        ST_CL_RDU,
        ST_CL_RDV,
        ST_CL_CMP,
        ST_FIN_RD,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] anc;
        logic              bad;
    } t_res;

    // memory row of a node id 1..MAX_NODES
    function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] t;
        t = node - NODE_W'(1);
        return t[IDX_W-1:0];
    endfunction

endpackage

### sv/blca_ram.sv
module blca_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/blca_ctrl.sv
module blca_ctrl
    import blca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_action,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_cfg_we,
    input  logic [NODE_W-1:0] i_cfg_data,
    output t_res              o_res,
    input  logic              i_res_rdy
);

    t_state r_state, n_state;
    logic [NODE_W-1:0] r_n, r_x, n_x, r_cur, n_cur, r_hops, n_hops;
    logic [NODE_W-1:0] r_u, n_u, r_v, n_v, r_du, n_du, r_dv, n_dv, r_t, n_t;
    logic [NODE_W-1:0] r_ranc, n_ranc;
    logic              r_rbad, n_rbad, r_built, n_built, r_az, r_dz;
    logic [LVL_W-1:0]  r_k, n_k, r_j, n_j, r_top, n_top, top_c;

    logic [NODE_W-1:0] neff, ancq, depq, p_c;
    logic              in_acc, last_x, q_bad, lift_go, walk_go;

    // memory controls
    logic              anc_we, dep_we, hp_we, hp_wdata, hp_rdata;
    logic [ANC_AW-1:0] anc_waddr, anc_raddr;
    logic [LVL_W-1:0]  anc_rlvl;
    logic [NODE_W-1:0] anc_wdata, anc_rnode, anc_rdata;
    logic [IDX_W-1:0]  dep_widx, hp_widx, hp_ridx;
    logic [NODE_W-1:0] dep_wdata, dep_rnode, dep_rdata;

    function automatic logic in_rng(input logic [NODE_W-1:0] id, input logic [NODE_W-1:0] n);
        return (id != '0) && (id <= n);
    endfunction

    assign neff    = (r_n > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : r_n;
    assign in_acc  = i_valid && (r_state == ST_IDLE);
    assign o_stall = (r_state != ST_IDLE);
    assign last_x  = (r_x == neff);
    assign q_bad   = !r_built || !in_rng(i_node_a, neff) || !in_rng(i_node_b, neff);
    assign ancq    = r_az ? '0 : anc_rdata;
    assign depq    = r_dz ? '0 : dep_rdata;
    assign p_c     = (hp_rdata && in_rng(ancq, neff)) ? ancq : '0;
    assign lift_go = ({1'b0, r_du} >= ({1'b0, r_dv} + (DW'(1) << r_j)));
    assign walk_go = (ancq != '0) && (r_hops < neff);
    assign anc_raddr = {anc_rlvl, node_idx(anc_rnode)};

    // highest level whose step fits in the deeper node's depth
    always_comb begin
        top_c = '0;
        for (int j = 0; j < LIFT_LEVELS; j++) begin
            if (int'(r_du) >= (1 << j)) top_c = LVL_W'(j);
        end
    end

    // memories
    blca_ram #(.W(NODE_W), .DEPTH(ANC_DEPTH), .AW(ANC_AW)) u_anc (
        .i_clk(i_clk), .i_we(anc_we), .i_waddr(anc_waddr), .i_wdata(anc_wdata),
        .i_raddr(anc_raddr), .o_rdata(anc_rdata)
    );
    blca_ram #(.W(NODE_W), .DEPTH(MAX_NODES), .AW(IDX_W)) u_dep (
        .i_clk(i_clk), .i_we(dep_we), .i_waddr(dep_widx), .i_wdata(dep_wdata),
        .i_raddr(node_idx(dep_rnode)), .o_rdata(dep_rdata)
    );
    blca_ram #(.W(1), .DEPTH(MAX_NODES), .AW(IDX_W)) u_hp (
        .i_clk(i_clk), .i_we(hp_we), .i_waddr(hp_widx), .i_wdata(hp_wdata),
        .i_raddr(hp_ridx), .o_rdata(hp_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_x == NODE_W'(MAX_NODES - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc && i_action == ACT_FINISH && neff != '0) n_state = ST_P1_RD;
                if (in_acc && i_action == ACT_QUERY) n_state = q_bad ? ST_OUT : ST_Q_RDU;
            end
            ST_P1_RD: n_state = ST_P1_WR;
            ST_P1_WR: n_state = last_x ? ST_D_RD : ST_P1_RD;
            ST_D_RD:  n_state = ST_D_CHK;
            ST_D_CHK: begin
                if (walk_go) n_state = ST_D_RD;
                else if (!last_x) n_state = ST_D_RD;
                else if (LIFT_LEVELS > 1) n_state = ST_L_RD;
                else n_state = ST_IDLE;
            end
            ST_L_RD:  n_state = ST_L_RD2;
            ST_L_RD2: n_state = ST_L_WR;
            ST_L_WR: begin
                if (last_x && r_k == LVL_W'(LIFT_LEVELS - 1)) n_state = ST_IDLE;
                else n_state = ST_L_RD;
            end
            ST_Q_RDU: n_state = ST_Q_RDV;
            ST_Q_RDV: n_state = ST_Q_TOP;
            ST_Q_TOP: n_state = ST_LIFT_CHK;
            ST_LIFT_CHK: begin
                if (lift_go) n_state = ST_LIFT_A;
                else if (r_j == '0) n_state = ST_AFTER;
            end
            ST_LIFT_A: n_state = ST_LIFT_D;
            ST_LIFT_D: n_state = (r_j == '0) ? ST_AFTER : ST_LIFT_CHK;
            ST_AFTER:  n_state = (r_u == r_v) ? ST_OUT : ST_CL_RDU;
            ST_CL_RDU: n_state = ST_CL_RDV;
            ST_CL_RDV: n_state = ST_CL_CMP;
            ST_CL_CMP: n_state = (r_j == '0) ? ST_FIN_RD : ST_CL_RDU;
            ST_FIN_RD: n_state = ST_FIN;
            ST_FIN:    n_state = ST_OUT;
            ST_OUT:    if (i_res_rdy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_x = r_x; n_cur = r_cur; n_hops = r_hops; n_u = r_u; n_v = r_v;
        n_du = r_du; n_dv = r_dv; n_t = r_t; n_k = r_k; n_j = r_j; n_top = r_top;
        n_ranc = r_ranc; n_rbad = r_rbad; n_built = r_built;
        anc_we = 1'b0; anc_waddr = '0; anc_wdata = '0; anc_rlvl = '0; anc_rnode = '0;
        dep_we = 1'b0; dep_widx = '0; dep_wdata = '0; dep_rnode = '0;
        hp_we = 1'b0; hp_widx = '0; hp_wdata = 1'b0; hp_ridx = '0;
        case (r_state)
            // parent flags cleared after reset
            ST_CLEAR: begin
                hp_we   = 1'b1;
                hp_widx = r_x[IDX_W-1:0];
                n_x     = r_x + NODE_W'(1);
            end
            ST_IDLE: begin
                if (in_acc && i_action == ACT_LOAD) begin
                    n_built = 1'b0;
                    if (in_rng(i_node_a, neff) && in_rng(i_node_b, neff)) begin
                        anc_we    = 1'b1;
                        anc_waddr = {LVL_W'(0), node_idx(i_node_b)};
                        anc_wdata = i_node_a;
                        hp_we     = 1'b1;
                        hp_widx   = node_idx(i_node_b);
                        hp_wdata  = 1'b1;
                    end
                end
                if (in_acc && i_action == ACT_FINISH) begin
                    n_x = NODE_W'(1);
                    if (neff == '0) n_built = 1'b1;
                end
                if (in_acc && i_action == ACT_QUERY) begin
                    n_u = i_node_a;
                    n_v = i_node_b;
                    dep_rnode = i_node_a;
                    n_ranc = '0;
                    n_rbad = q_bad;
                end
            end
            // level 0 clean-up: drop missing or stale parents
            ST_P1_RD: begin
                anc_rnode = r_x;
                hp_ridx   = node_idx(r_x);
            end
            ST_P1_WR: begin
                anc_we    = 1'b1;
                anc_waddr = {LVL_W'(0), node_idx(r_x)};
                anc_wdata = p_c;
                if (last_x) begin
                    n_x = NODE_W'(1); n_cur = NODE_W'(1); n_hops = '0;
                end else begin
                    n_x = r_x + NODE_W'(1);
                end
            end
            // depth walk up the parent chain
            ST_D_RD: anc_rnode = r_cur;
            ST_D_CHK: begin
                if (walk_go) begin
                    n_cur  = ancq;
                    n_hops = r_hops + NODE_W'(1);
                end else begin
                    dep_we    = 1'b1;
                    dep_widx  = node_idx(r_x);
                    dep_wdata = (r_hops >= neff) ? neff : r_hops + NODE_W'(1);
                    n_hops    = '0;
                    if (last_x) begin
                        n_x = NODE_W'(1);
                        n_k = LVL_W'(1);
                        if (LIFT_LEVELS == 1) n_built = 1'b1;
                    end else begin
                        n_x   = r_x + NODE_W'(1);
                        n_cur = r_x + NODE_W'(1);
                    end
                end
            end
            // doubling: anc[k][x] = anc[k-1][anc[k-1][x]]
            ST_L_RD: begin
                anc_rlvl  = r_k - LVL_W'(1);
                anc_rnode = r_x;
            end
            ST_L_RD2: begin
                anc_rlvl  = r_k - LVL_W'(1);
                anc_rnode = ancq;
            end
            ST_L_WR: begin
                anc_we    = 1'b1;
                anc_waddr = {r_k, node_idx(r_x)};
                anc_wdata = ancq;
                if (last_x) begin
                    n_x = NODE_W'(1);
                    if (r_k == LVL_W'(LIFT_LEVELS - 1)) n_built = 1'b1;
                    else n_k = r_k + LVL_W'(1);
                end else begin
                    n_x = r_x + NODE_W'(1);
                end
            end
            // query: depths, order the pair
            ST_Q_RDU: begin
                n_du = depq;
                dep_rnode = r_v;
            end
            ST_Q_RDV: begin
                if (r_du < depq) begin
                    n_u = r_v; n_v = r_u; n_du = depq; n_dv = r_du;
                end else begin
                    n_dv = depq;
                end
            end
            ST_Q_TOP: begin
                n_top = top_c;
                n_j   = top_c;
            end
            // lift the deeper node
            ST_LIFT_CHK: begin
                if (lift_go) begin
                    anc_rlvl  = r_j;
                    anc_rnode = r_u;
                end else if (r_j != '0) begin
                    n_j = r_j - LVL_W'(1);
                end
            end
            ST_LIFT_A: begin
                n_u = ancq;
                dep_rnode = ancq;
            end
            ST_LIFT_D: begin
                n_du = depq;
                if (r_j != '0) n_j = r_j - LVL_W'(1);
            end
            ST_AFTER: begin
                n_ranc = r_u;
                n_j    = r_top;
            end
            // climb both while ancestors differ
            ST_CL_RDU: begin
                anc_rlvl  = r_j;
                anc_rnode = r_u;
            end
            ST_CL_RDV: begin
                n_t = ancq;
                anc_rlvl  = r_j;
                anc_rnode = r_v;
            end
            ST_CL_CMP: begin
                if (r_t != ancq) begin
                    n_u = r_t;
                    n_v = ancq;
                end
                if (r_j != '0) n_j = r_j - LVL_W'(1);
            end
            ST_FIN_RD: anc_rnode = r_u;
            ST_FIN:    n_ranc = ancq;
            ST_OUT: ;
            default: ;
        endcase
        // register write clears the built flag
        if (i_cfg_we) n_built = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_x     <= '0;
            r_n     <= NODE_W'(1);
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
            r_built <= n_built;
            if (i_cfg_we) r_n <= i_cfg_data;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur; r_hops <= n_hops; r_u <= n_u; r_v <= n_v;
        r_du <= n_du; r_dv <= n_dv; r_t <= n_t; r_k <= n_k; r_j <= n_j;
        r_top <= n_top; r_ranc <= n_ranc; r_rbad <= n_rbad;
        r_az <= (anc_rnode == '0);
        r_dz <= (dep_rnode == '0);
    end

    assign o_res.vld = (r_state == ST_OUT);
    assign o_res.anc = r_ranc;
    assign o_res.bad = r_rbad;

endmodule

### sv/binary_lifting_lca.sv
// Lowest common ancestor by binary lifting over a loaded tree.
// Input channel: i_valid / o_stall with i_action, i_node_a, i_node_b. A beat
// with action load stores an edge (parent a, child b), finish builds the
// depth and ancestor tables, query returns one result beat. A load does not
// leave the idle state. Output channel: o_valid / i_stall with o_ancestor_node and
// o_bad_query; only queries produce a beat.
// Config: i_cfg_we / i_cfg_data writes node_count; user writes only while idle, unchecked.
// Query: both depths are read and the pair ordered, then the levels are scanned
// from the top down (up to ten), a lift step reading the ancestor and its depth;
// a pair that still differs after lifting climbs each level from the top down
// (reads for u and v, then a compare) and reads the final parent. A flagged query
// goes straight to the output. Each step waits on the previous read of the
// ancestor memory, and the next beat is taken once the result has moved to the
// output register. Finish: level 0 reads and rewrites each parent, the depth
// walk reads one parent per hop, then each further level reads two per node.
// Reset: synchronous, active low. After reset a pass over every row clears the
// parent flags; o_stall is high during it, config writes are taken.
// A result held by i_stall sits in the output register while the core goes
// on with the next beat; it waits only if it has a second result ready.
module binary_lifting_lca
    import blca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_action,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_cfg_we,
    input  logic [NODE_W-1:0] i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [NODE_W-1:0] o_ancestor_node,
    output logic              o_bad_query
);

    t_res              res;
    logic              res_rdy;
    logic              r_ovld;
    logic [NODE_W-1:0] r_oanc;
    logic              r_obad;

    blca_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_node_a(i_node_a), .i_node_b(i_node_b),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_res(res), .i_res_rdy(res_rdy)
    );

    assign res_rdy = !r_ovld || !i_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (res_rdy) begin
            r_ovld <= res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res.vld) begin
            r_oanc <= res.anc;
            r_obad <= res.bad;
        end
    end

    assign o_valid         = r_ovld;
    assign o_ancestor_node = r_oanc;
    assign o_bad_query     = r_obad;

endmodule

### sv/blca_chk.sv
module blca_chk
    import blca_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [NODE_W-1:0] o_ancestor_node,
    input logic              o_bad_query
);

    // held beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ancestor_node) && $stable(o_bad_query))
        else $error("output beat dropped or changed under stall");

    // flagged query answers none
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_query |-> o_ancestor_node == '0)
        else $error("flagged query with nonzero ancestor");

    // answer is zero or a node id
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_ancestor_node <= NODE_W'(MAX_NODES))
        else $error("ancestor out of node range");

    // nothing out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind binary_lifting_lca blca_chk u_blca_chk (.*);

### bench/tb_binary_lifting_lca.sv
`timescale 1ns / 100ps

module tb_binary_lifting_lca;
    import blca_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [1:0]        action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_item;

    typedef struct {
        logic [NODE_W-1:0] anc;
        logic              bad;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_action = ACT_LOAD;
    logic [NODE_W-1:0] i_node_a = '0;
    logic [NODE_W-1:0] i_node_b = '0;
    logic              i_cfg_we = 1'b0;
    logic [NODE_W-1:0] i_cfg_data = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [NODE_W-1:0] o_ancestor_node;
    logic              o_bad_query;

    binary_lifting_lca DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_node_a(i_node_a), .i_node_b(i_node_b),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_ancestor_node(o_ancestor_node), .o_bad_query(o_bad_query)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the block state
    int      parent_of [0:MAX_NODES][0:LIFT_LEVELS-1];
    int      depth_of [0:MAX_NODES];
    bit      has_parent [0:MAX_NODES];
    int      node_count = 1;
    bit      tables_built = 0;
    int      build_cycles = 0;

    t_item   pending_items[$];
    t_answer lca_answers[$];
    int      errors = 0;
    int      items_queued = 0;
    int      queries_seen = 0;
    int      phases_run = 0;
    bit      quiet = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    bit      stall_mode = 0;

    function automatic int eff_nodes();
        return node_count > MAX_NODES ? MAX_NODES : node_count;
    endfunction

    // fill depth and ancestor tables on finish
    function automatic void build_lift_tables();
        int n, p, cur, hops, sum;
        n = eff_nodes();
        sum = 0;
        for (int k = 0; k < LIFT_LEVELS; k++) parent_of[0][k] = 0;
        for (int x = 1; x <= n; x++) begin
            p = has_parent[x] ? parent_of[x][0] : 0;
            if (p < 1 || p > n) p = 0;
            parent_of[x][0] = p;
        end
        for (int x = 1; x <= n; x++) begin
            cur = x;
            hops = 0;
            while (parent_of[cur][0] != 0 && hops < n) begin
                cur = parent_of[cur][0];
                hops++;
            end
            depth_of[x] = (hops + 1 > n) ? n : hops + 1;
            sum += depth_of[x];
        end
        for (int k = 1; k < LIFT_LEVELS; k++)
            for (int x = 1; x <= n; x++)
                parent_of[x][k] = parent_of[parent_of[x][k-1]][k-1];
        tables_built = 1;
        build_cycles = 2 * n + 2 * sum + 3 * n * LIFT_LEVELS;
    endfunction

    function automatic int lowest_common(int u, int v);
        int t, top;
        if (depth_of[u] < depth_of[v]) begin
            t = u; u = v; v = t;
        end
        top = -1;
        while (top + 1 < LIFT_LEVELS && (1 << (top + 1)) <= depth_of[u]) top++;
        for (int j = top; j >= 0; j--)
            if (depth_of[u] >= depth_of[v] + (1 << j)) u = parent_of[u][j];
        if (u == v) return u;
        for (int j = top; j >= 0; j--)
            if (parent_of[u][j] != parent_of[v][j]) begin
                u = parent_of[u][j];
                v = parent_of[v][j];
            end
        return parent_of[u][0];
    endfunction

    function automatic void apply_beat(t_item it);
        int n, a, b;
        t_answer ans;
        n = eff_nodes();
        a = it.node_a;
        b = it.node_b;
        case (it.action)
            ACT_LOAD: begin
                tables_built = 0;
                if (a >= 1 && a <= n && b >= 1 && b <= n) begin
                    parent_of[b][0] = a;
                    has_parent[b] = 1;
                end
            end
            ACT_FINISH: build_lift_tables();
            ACT_QUERY: begin
                if (!tables_built || a < 1 || a > n || b < 1 || b > n) begin
                    ans.anc = '0;
                    ans.bad = 1'b1;
                end else begin
                    ans.anc = NODE_W'(lowest_common(a, b));
                    ans.bad = 1'b0;
                end
                lca_answers.insert(lca_answers.size(), ans);
            end
            default: ;
        endcase
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                it.action = i_action;
                it.node_a = i_node_a;
                it.node_b = i_node_b;
                apply_beat(it);
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_action <= it.action;
                    i_node_a <= it.node_a;
                    i_node_b <= it.node_b;
                    if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                queries_seen++;
                if (lca_answers.size() == 0) begin
                    report("unexpected beat, ancestor", o_ancestor_node, -1);
                end else begin
                    want = lca_answers.pop_front();
                    if (o_ancestor_node !== want.anc)
                        report("ancestor_node", o_ancestor_node, want.anc);
                    if (o_bad_query !== want.bad)
                        report("bad_query", o_bad_query, want.bad);
                end
            end
            if (stall_left == 0) begin
                stall_mode = !quiet && $urandom_range(0, 3) == 0;
                stall_left = $urandom_range(1, 15);
            end
            stall_left--;
            i_stall <= stall_mode;
        end
    end

    task automatic push(logic [1:0] act, int a, int b);
        t_item it;
        it.action = act;
        it.node_a = NODE_W'(a);
        it.node_b = NODE_W'(b);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // drain everything, let a finish run out, then the block is idle
    task automatic settle();
        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (lca_answers.size() > 0) @(posedge i_clk);
        repeat (build_cycles + 200) @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        build_cycles = 0;
    endtask

    task automatic write_count(int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= NODE_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_count = v & 11'h7FF;
        tables_built = 0;
    endtask

    task automatic random_query(int n);
        int a, b;
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        if ($urandom_range(0, 15) == 0) a = $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 2047);
        if ($urandom_range(0, 15) == 0) b = $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 2047);
        push(ACT_QUERY, a, b);
    endtask

    // one phase: tree of a random shape, finish, queries, with some noise
    task automatic tree_phase(int n, int queries);
        int shape;
        shape = $urandom_range(0, 3);
        if (n > 64 && shape != 0) shape = 0;
        write_count(n);
        n = eff_nodes();
        if ($urandom_range(0, 5) == 0) random_query(n);
        for (int x = 2; x <= n; x++) begin
            case (shape)
                0: push(ACT_LOAD, $urandom_range(1, x - 1), x);
                1: push(ACT_LOAD, x - 1, x);
                2: if ($urandom_range(0, 9) != 0) push(ACT_LOAD, $urandom_range(1, x - 1), x);
                default: begin
                    push(ACT_LOAD, $urandom_range(1, x - 1), x);
                    if ($urandom_range(0, 3) == 0)
                        push(ACT_LOAD, $urandom_range(0, 2047), $urandom_range(0, 2047));
                    if ($urandom_range(0, 5) == 0) push(ACT_NONE, $urandom, $urandom);
                end
            endcase
        end
        if (shape == 3 && $urandom_range(0, 1)) push(ACT_LOAD, n, 1);
        push(ACT_FINISH, $urandom, $urandom);
        for (int q = 0; q < queries; q++) begin
            random_query(n);
            if (n > 1 && $urandom_range(0, 60) == 0) begin
                push(ACT_LOAD, $urandom_range(1, n - 1), n);
                random_query(n);
                push(ACT_FINISH, 0, 0);
            end
        end
        settle();
        phases_run++;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default count of one: queries before finish, unused action, self parent
        push(ACT_QUERY, 1, 1);
        push(ACT_NONE, 2047, 2047);
        push(ACT_FINISH, 0, 0);
        push(ACT_QUERY, 1, 1);
        push(ACT_QUERY, 0, 1);
        push(ACT_QUERY, 1, 2047);
        push(ACT_LOAD, 1, 1);
        push(ACT_FINISH, 0, 0);
        push(ACT_QUERY, 1, 1);
        settle();

        // zero nodes: everything flagged
        write_count(0);
        push(ACT_FINISH, 0, 0);
        push(ACT_QUERY, 1, 1);
        push(ACT_QUERY, 0, 0);
        settle();

        // small forest with reload, out of range edge, stale parent
        write_count(8);
        push(ACT_LOAD, 1, 2);
        push(ACT_LOAD, 1, 3);
        push(ACT_LOAD, 2, 4);
        push(ACT_LOAD, 3, 4);
        push(ACT_LOAD, 9, 5);
        push(ACT_LOAD, 4, 6);
        push(ACT_LOAD, 7, 8);
        push(ACT_FINISH, 0, 0);
        push(ACT_QUERY, 6, 2);
        push(ACT_QUERY, 6, 8);
        push(ACT_QUERY, 4, 3);
        push(ACT_QUERY, 9, 1);
        push(ACT_LOAD, 4, 5);
        push(ACT_QUERY, 5, 6);
        settle();
        write_count(4);
        push(ACT_FINISH, 0, 0);
        push(ACT_QUERY, 4, 3);
        push(ACT_QUERY, 2, 1);
        settle();

        // widest tree, through a clamped count
        tree_phase(2047, 20);

        while (items_queued < 1090) tree_phase($urandom_range(2, 30), $urandom_range(10, 30));

        quiet = 1;
        tree_phase($urandom_range(2, 20), 30);

        $display("ran %0d tree phases, %0d input beats, %0d query results checked",
                 phases_run, items_queued, queries_seen);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
